@@ hdl/header_length_checksum_frame_receiver_core_assert.svh @@
// assertion macros for the checker file of the frame receiver
`ifndef HEADER_LENGTH_CHECKSUM_FRAME_RECEIVER_CORE_ASSERT_SVH
`define HEADER_LENGTH_CHECKSUM_FRAME_RECEIVER_CORE_ASSERT_SVH

// consequence must hold in the same cycle as the antecedent
`define HLCFR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence must hold in the cycle after the antecedent
`define HLCFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/hlcfr_pkg.sv @@
// shared types, codes and constants of the frame receiver
`default_nettype none

package hlcfr_pkg;

  // field widths
  localparam int BYTE_W    = 8;
  localparam int MODE_W    = 2;
  localparam int SEL_W     = 4;
  localparam int POS_IN_W  = 4;
  localparam int EV_W      = 3;
  localparam int LEN_OUT_W = 5;
  localparam int CNT_W     = 5;
  localparam int SUM_W     = 4;
  localparam int CFG_IDX_W = 1;

  // request codes
  localparam logic [MODE_W-1:0] MODE_BYTE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ    = 2'd3;

  // event codes
  localparam logic [EV_W-1:0] EV_VALID   = 3'd0;
  localparam logic [EV_W-1:0] EV_CSUM    = 3'd1;
  localparam logic [EV_W-1:0] EV_BADLEN  = 3'd2;
  localparam logic [EV_W-1:0] EV_TIMEOUT = 3'd3;
  localparam logic [EV_W-1:0] EV_READ    = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  // register reset values and fixed limits
  localparam logic [BYTE_W-1:0] HEADER_RESET  = 8'hA5;
  localparam logic [BYTE_W-1:0] TIMEOUT_RESET = 8'd10;
  localparam logic [BYTE_W-1:0] IDLE_MAX      = 8'hFF;
  localparam int                MIN_FRAME_LEN = 3;

  // one request beat
  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [BYTE_W-1:0]   rx_byte;
    logic [SEL_W-1:0]    slot_sel;
    logic [POS_IN_W-1:0] byte_pos;
  } hlcfr_item_t;

  // one result beat
  typedef struct packed {
    logic [EV_W-1:0]      event_res;
    logic [SEL_W-1:0]     slot_index;
    logic [LEN_OUT_W-1:0] frame_length;
    logic [BYTE_W-1:0]    read_byte;
    logic [CNT_W-1:0]     slots_used;
  } hlcfr_result_t;

endpackage

`default_nettype wire

@@ hdl/hlcfr_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module hlcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/hlcfr_engine.sv @@
// frame state, slot bookkeeping and result decode for one beat per cycle while fire is high
`default_nettype none

module hlcfr_engine #(
  parameter int NUM_SLOTS  = 4,
  parameter int SLOT_BYTES = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  fire,
  input  wire hlcfr_pkg::hlcfr_item_t                item,
  input  wire logic [hlcfr_pkg::BYTE_W-1:0]          header_value,
  input  wire logic [hlcfr_pkg::BYTE_W-1:0]          timeout_ticks,
  input  wire logic [hlcfr_pkg::BYTE_W-1:0]          rd_byte,
  output logic                                       res_valid,
  output hlcfr_pkg::hlcfr_result_t                   res,
  output logic                                       wr_en,
  output logic [$clog2(NUM_SLOTS*SLOT_BYTES)-1:0]    wr_addr,
  output logic [hlcfr_pkg::BYTE_W-1:0]               wr_data
);

  import hlcfr_pkg::*;

  localparam int SLOT_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int SLOT_CNT = 1 << SLOT_W;
  localparam int POS_W    = $clog2(SLOT_BYTES);
  localparam int LEN_W    = $clog2(SLOT_BYTES + 1);
  localparam int ADDR_W   = $clog2(NUM_SLOTS * SLOT_BYTES);
  localparam logic [ADDR_W-1:0] SLOT_STRIDE = ADDR_W'(SLOT_BYTES);

  logic                in_frame_r, in_frame_nxt;
  logic [POS_W-1:0]    bytes_taken_r, bytes_taken_nxt;
  logic [LEN_W-1:0]    exp_len_r, exp_len_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SLOT_W-1:0]   write_slot_r, write_slot_nxt;
  logic [SLOT_CNT-1:0] slot_full_r, slot_full_nxt;
  logic [CNT_W-1:0]    full_count_r, full_count_nxt;
  logic [BYTE_W-1:0]   idle_r, idle_nxt;

  logic                is_hdr;
  logic [POS_W-1:0]    bt_base;
  logic [LEN_W-1:0]    exp_base;
  logic [SUM_W-1:0]    sum_base;
  logic [LEN_W-1:0]    bt_inc;
  logic [SUM_W-1:0]    sum_add;
  logic                slot_busy;
  logic                bad_len;
  logic                sum_good;
  logic [BYTE_W-1:0]   idle_inc;
  logic                sel_ok;
  logic [SLOT_W-1:0]   sel_idx;

  // a header restarts the frame from a clean state
  assign is_hdr    = (item.rx_byte == header_value);
  assign bt_base   = is_hdr ? '0 : bytes_taken_r;
  assign exp_base  = is_hdr ? '0 : exp_len_r;
  assign sum_base  = is_hdr ? '0 : sum_r;
  assign bt_inc    = LEN_W'(bt_base) + LEN_W'(1);
  assign sum_add   = sum_base + item.rx_byte[SUM_W-1:0];
  assign slot_busy = slot_full_r[write_slot_r];
  assign bad_len   = (item.rx_byte < BYTE_W'(MIN_FRAME_LEN)) ||
                     (item.rx_byte > BYTE_W'(SLOT_BYTES));
  assign sum_good  = ({{(BYTE_W-SUM_W){1'b0}}, sum_base} == item.rx_byte);
  assign idle_inc  = (idle_r == IDLE_MAX) ? idle_r : idle_r + 8'd1;
  assign sel_ok    = ({1'b0, item.slot_sel} < (SEL_W+1)'(NUM_SLOTS));
  assign sel_idx   = item.slot_sel[SLOT_W-1:0];

  // store write address of the current byte
  assign wr_addr = ADDR_W'(write_slot_r) * SLOT_STRIDE + ADDR_W'(bt_base);
  assign wr_data = item.rx_byte;

  // next state and result
  always_comb begin
    in_frame_nxt    = in_frame_r;
    bytes_taken_nxt = bytes_taken_r;
    exp_len_nxt     = exp_len_r;
    sum_nxt         = sum_r;
    write_slot_nxt  = write_slot_r;
    slot_full_nxt   = slot_full_r;
    full_count_nxt  = full_count_r;
    idle_nxt        = idle_r;
    res_valid       = 1'b0;
    res             = '0;
    wr_en           = 1'b0;

    unique case (item.mode)
      MODE_BYTE: begin
        if (is_hdr || in_frame_r) begin
          in_frame_nxt    = 1'b1;
          idle_nxt        = '0;
          bytes_taken_nxt = bt_base;
          exp_len_nxt     = exp_base;
          sum_nxt         = sum_base;
          if (!slot_busy) begin
            wr_en = fire;
            if (bt_inc == LEN_W'(2)) begin
              // length byte
              if (bad_len) begin
                in_frame_nxt    = 1'b0;
                bytes_taken_nxt = '0;
                exp_len_nxt     = '0;
                sum_nxt         = '0;
                res_valid       = 1'b1;
                res.event_res   = EV_BADLEN;
                res.slot_index  = SEL_W'(write_slot_r);
              end else begin
                exp_len_nxt     = item.rx_byte[LEN_W-1:0];
                bytes_taken_nxt = bt_inc[POS_W-1:0];
                sum_nxt         = sum_add;
              end
            end else if (bt_inc >= LEN_W'(MIN_FRAME_LEN) && bt_inc == exp_base) begin
              // last byte carries the checksum
              in_frame_nxt     = 1'b0;
              bytes_taken_nxt  = '0;
              exp_len_nxt      = '0;
              sum_nxt          = '0;
              write_slot_nxt   = (write_slot_r == SLOT_W'(NUM_SLOTS - 1)) ?
                                 '0 : write_slot_r + SLOT_W'(1);
              res_valid        = 1'b1;
              res.slot_index   = SEL_W'(write_slot_r);
              res.frame_length = LEN_OUT_W'(exp_base);
              if (sum_good) begin
                slot_full_nxt[write_slot_r] = 1'b1;
                full_count_nxt              = full_count_r + CNT_W'(1);
                res.event_res               = EV_VALID;
              end else begin
                res.event_res = EV_CSUM;
              end
            end else begin
              bytes_taken_nxt = bt_inc[POS_W-1:0];
              sum_nxt         = sum_add;
            end
          end
        end
      end
      MODE_TICK: begin
        if (in_frame_r) begin
          if (idle_inc > timeout_ticks) begin
            in_frame_nxt    = 1'b0;
            bytes_taken_nxt = '0;
            exp_len_nxt     = '0;
            sum_nxt         = '0;
            idle_nxt        = '0;
            res_valid       = 1'b1;
            res.event_res   = EV_TIMEOUT;
            res.slot_index  = SEL_W'(write_slot_r);
          end else begin
            idle_nxt = idle_inc;
          end
        end
      end
      MODE_RELEASE: begin
        if (sel_ok && slot_full_r[sel_idx]) begin
          slot_full_nxt[sel_idx] = 1'b0;
          if (full_count_r != '0) begin
            full_count_nxt = full_count_r - CNT_W'(1);
          end
        end
      end
      MODE_READ: begin
        res_valid      = 1'b1;
        res.event_res  = EV_READ;
        res.slot_index = item.slot_sel;
        res.read_byte  = rd_byte;
      end
    endcase

    res.slots_used = full_count_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r    <= 1'b0;
      bytes_taken_r <= '0;
      exp_len_r     <= '0;
      sum_r         <= '0;
      write_slot_r  <= '0;
      slot_full_r   <= '0;
      full_count_r  <= '0;
      idle_r        <= '0;
    end else if (fire) begin
      in_frame_r    <= in_frame_nxt;
      bytes_taken_r <= bytes_taken_nxt;
      exp_len_r     <= exp_len_nxt;
      sum_r         <= sum_nxt;
      write_slot_r  <= write_slot_nxt;
      slot_full_r   <= slot_full_nxt;
      full_count_r  <= full_count_nxt;
      idle_r        <= idle_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/header_length_checksum_frame_receiver_core.sv @@
// Frame receiver with header byte, length byte and 4-bit checksum, storing frames in a ring
// of NUM_SLOTS slots of SLOT_BYTES bytes. Each input beat is a received byte, a timer tick,
// a slot release or a read of one stored byte; it yields at most one result beat. One beat
// is accepted every clock while no stalled result holds it: a beat is held in the input
// register (where the frame store read for a read request also completes), is resolved
// there against the frame state in one pass, and its result is then captured in the output
// register. A result waiting on out_ready holds the input register and so the input.
// The throughput of one beat per cycle is set by the single store write and the single-pass
// state update of the frame engine. The frame store is not cleared after reset; reading a
// byte that was never written returns an unspecified value.
`default_nettype none

module header_length_checksum_frame_receiver_core #(
  parameter int NUM_SLOTS  = 4,
  parameter int SLOT_BYTES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [hlcfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hlcfr_pkg::BYTE_W-1:0]      cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [hlcfr_pkg::MODE_W-1:0]      in_mode,
  input  wire logic [hlcfr_pkg::BYTE_W-1:0]      in_rx_byte,
  input  wire logic [hlcfr_pkg::SEL_W-1:0]       in_slot_sel,
  input  wire logic [hlcfr_pkg::POS_IN_W-1:0]    in_byte_pos,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [hlcfr_pkg::EV_W-1:0]             out_event_res,
  output logic [hlcfr_pkg::SEL_W-1:0]            out_slot_index,
  output logic [hlcfr_pkg::LEN_OUT_W-1:0]        out_frame_length,
  output logic [hlcfr_pkg::BYTE_W-1:0]           out_read_byte,
  output logic [hlcfr_pkg::CNT_W-1:0]            out_slots_used
);

  import hlcfr_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int POS_W  = $clog2(SLOT_BYTES);
  localparam int DEPTH  = NUM_SLOTS * SLOT_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] SLOT_STRIDE = ADDR_W'(SLOT_BYTES);

  logic [BYTE_W-1:0] header_r;
  logic [BYTE_W-1:0] timeout_r;

  logic              in_fire;
  logic              s1_fire;
  logic              s1_valid_r;
  hlcfr_item_t       item_r;
  logic              rd_ok_r;
  logic              byp_r;
  logic [BYTE_W-1:0] byp_data_r;

  logic              rd_ok_nxt;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] ram_q;
  logic [BYTE_W-1:0] rd_byte;

  logic              res_valid;
  hlcfr_result_t     res;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;

  logic              out_valid_r;
  hlcfr_result_t     out_res_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= HEADER_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER:  header_r  <= cfg_data;
        CFG_TIMEOUT: timeout_r <= cfg_data;
      endcase
    end
  end

  // handshake: input register moves on when the output register can take its result
  assign in_fire  = in_valid && in_ready;
  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  // store read address taken straight from the incoming beat
  assign rd_ok_nxt = ({1'b0, in_slot_sel} < (SEL_W+1)'(NUM_SLOTS)) &&
                     ({1'b0, in_byte_pos} < (POS_IN_W+1)'(SLOT_BYTES));
  assign rd_addr   = ADDR_W'(in_slot_sel[SLOT_W-1:0]) * SLOT_STRIDE +
                     ADDR_W'(in_byte_pos[POS_W-1:0]);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // beat payload, read range flag and forwarding of a write to the same byte
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r     <= '{mode: in_mode, rx_byte: in_rx_byte,
                      slot_sel: in_slot_sel, byte_pos: in_byte_pos};
      rd_ok_r    <= rd_ok_nxt;
      byp_r      <= wr_en && (wr_addr == rd_addr);
      byp_data_r <= wr_data;
    end
  end

  hlcfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_hlcfr_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // read data: zero out of range, else the freshest copy
  assign rd_byte = !rd_ok_r ? '0 : (byp_r ? byp_data_r : ram_q);

  hlcfr_engine #(
    .NUM_SLOTS  (NUM_SLOTS),
    .SLOT_BYTES (SLOT_BYTES)
  ) u_hlcfr_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (s1_fire),
    .item          (item_r),
    .header_value  (header_r),
    .timeout_ticks (timeout_r),
    .rd_byte       (rd_byte),
    .res_valid     (res_valid),
    .res           (res),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= res_valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_res_r.event_res;
  assign out_slot_index   = out_res_r.slot_index;
  assign out_frame_length = out_res_r.frame_length;
  assign out_read_byte    = out_res_r.read_byte;
  assign out_slots_used   = out_res_r.slots_used;

endmodule

`default_nettype wire

@@ hdl/hlcfr_checker.sv @@
// port-level checks of the frame receiver and their bind to the top level
`default_nettype none

`include "header_length_checksum_frame_receiver_core_assert.svh"

module hlcfr_checker #(
  parameter int NUM_SLOTS  = 4,
  parameter int SLOT_BYTES = 16
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [hlcfr_pkg::EV_W-1:0]        out_event_res,
  input wire logic [hlcfr_pkg::SEL_W-1:0]       out_slot_index,
  input wire logic [hlcfr_pkg::LEN_OUT_W-1:0]   out_frame_length,
  input wire logic [hlcfr_pkg::BYTE_W-1:0]      out_read_byte,
  input wire logic [hlcfr_pkg::CNT_W-1:0]       out_slots_used
);

  import hlcfr_pkg::*;

  // a stalled result beat holds
  `HLCFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_event_res) && $stable(out_slot_index) && $stable(out_frame_length) && $stable(out_read_byte) && $stable(out_slots_used), "result beat changed while stalled")

  // completed frames report a length the slot can hold
  `HLCFR_ASSERT_SAME(a_frame_len, out_valid && (out_event_res == EV_VALID || out_event_res == EV_CSUM), out_frame_length >= LEN_OUT_W'(MIN_FRAME_LEN) && out_frame_length <= LEN_OUT_W'(SLOT_BYTES), "frame length out of range")

  // only read beats carry data, only frame beats carry a length
  `HLCFR_ASSERT_SAME(a_read_zero, out_valid && out_event_res != EV_READ, out_read_byte == '0 && (out_event_res == EV_VALID || out_event_res == EV_CSUM || out_frame_length == '0), "stray read data or length")

  // occupied slot count never exceeds the ring size
  `HLCFR_ASSERT_SAME(a_used_max, out_valid, out_slots_used <= CNT_W'(NUM_SLOTS), "slot count above ring size")

endmodule

bind header_length_checksum_frame_receiver_core hlcfr_checker #(
  .NUM_SLOTS  (NUM_SLOTS),
  .SLOT_BYTES (SLOT_BYTES)
) u_hlcfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_event_res    (out_event_res),
  .out_slot_index   (out_slot_index),
  .out_frame_length (out_frame_length),
  .out_read_byte    (out_read_byte),
  .out_slots_used   (out_slots_used)
);

`default_nettype wire

@@ sim/tb.sv @@
// self-checking testbench for the header/length/checksum frame receiver
module tb;
  import hlcfr_pkg::*;

  localparam int NUM_SLOTS   = 4;
  localparam int SLOT_BYTES  = 16;
  localparam int STORE_BYTES = NUM_SLOTS * SLOT_BYTES;
  localparam int DRAIN_PAUSE = 4;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  // frame engine shadow and queue of result beats still owed by the block
  class frame_scoreboard;
    logic [BYTE_W-1:0] header_value;
    logic [BYTE_W-1:0] timeout_ticks;
    bit                in_frame;
    int                bytes_taken;
    logic [BYTE_W-1:0] expected_length;
    logic [SUM_W-1:0]  running_sum;
    int                write_slot;
    bit                slot_full[NUM_SLOTS];
    int                full_count;
    logic [BYTE_W-1:0] idle_ticks;
    logic [BYTE_W-1:0] frame_store[STORE_BYTES];
    bit                written[STORE_BYTES];
    hlcfr_result_t     owed_beats[$];
    int                errors;

    function new();
      header_value    = HEADER_RESET;
      timeout_ticks   = TIMEOUT_RESET;
      expected_length = '0;
      running_sum     = '0;
      idle_ticks      = '0;
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch at %0t: %s", $time, msg);
    endtask

    function void close_frame();
      in_frame        = 1'b0;
      bytes_taken     = 0;
      expected_length = '0;
      running_sum     = '0;
      idle_ticks      = '0;
    endfunction

    function void owe_beat(logic [EV_W-1:0] ev, int slot, int len, logic [BYTE_W-1:0] rd);
      hlcfr_result_t r;
      r.event_res    = ev;
      r.slot_index   = SEL_W'(slot);
      r.frame_length = LEN_OUT_W'(len);
      r.read_byte    = rd;
      r.slots_used   = CNT_W'(full_count);
      owed_beats.push_back(r);
    endfunction

    // one received byte: restart on header, store, length and checksum checks
    function void take_byte(logic [BYTE_W-1:0] b);
      int  slot;
      int  len;
      bit  good;
      slot = write_slot;
      if (b == header_value) begin
        close_frame();
        in_frame = 1'b1;
      end else if (!in_frame) begin
        return;
      end
      idle_ticks = '0;
      if (slot_full[slot]) return;
      frame_store[slot * SLOT_BYTES + bytes_taken] = b;
      written[slot * SLOT_BYTES + bytes_taken]     = 1'b1;
      bytes_taken++;
      if (bytes_taken == 2) begin
        expected_length = b;
        if (b < MIN_FRAME_LEN || b > SLOT_BYTES) begin
          close_frame();
          owe_beat(EV_BADLEN, slot, 0, '0);
          return;
        end
      end
      if (bytes_taken >= MIN_FRAME_LEN && bytes_taken == int'(expected_length)) begin
        len  = expected_length;
        good = ({4'h0, running_sum} == b);
        close_frame();
        if (good) begin
          slot_full[slot] = 1'b1;
          full_count++;
        end
        write_slot = (slot + 1 >= NUM_SLOTS) ? 0 : slot + 1;
        owe_beat(good ? EV_VALID : EV_CSUM, slot, len, '0);
        return;
      end
      running_sum = running_sum + b[SUM_W-1:0];
    endfunction

    // accepted input beat
    function void note_request(hlcfr_item_t it);
      int idx;
      case (it.mode)
        MODE_BYTE: take_byte(it.rx_byte);
        MODE_TICK: begin
          if (in_frame) begin
            if (idle_ticks != IDLE_MAX) idle_ticks++;
            if (idle_ticks > timeout_ticks) begin
              close_frame();
              owe_beat(EV_TIMEOUT, write_slot, 0, '0);
            end
          end
        end
        MODE_RELEASE: begin
          if (it.slot_sel < NUM_SLOTS && slot_full[it.slot_sel]) begin
            slot_full[it.slot_sel] = 1'b0;
            if (full_count > 0) full_count--;
          end
        end
        MODE_READ: begin
          if (it.slot_sel < NUM_SLOTS) begin
            idx = int'(it.slot_sel) * SLOT_BYTES + int'(it.byte_pos);
            owe_beat(EV_READ, it.slot_sel, 0, frame_store[idx]);
          end else begin
            owe_beat(EV_READ, it.slot_sel, 0, '0);
          end
        end
      endcase
    endfunction

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // accepted result beat against the oldest one owed
    task check_result(hlcfr_result_t got);
      hlcfr_result_t want;
      if (owed_beats.size() == 0) begin
        report($sformatf("result beat 0x%0h with nothing expected", got));
        return;
      end
      want = owed_beats.pop_front();
      compare_field("event_res", 8'(got.event_res), 8'(want.event_res));
      compare_field("slot_index", 8'(got.slot_index), 8'(want.slot_index));
      compare_field("frame_length", 8'(got.frame_length), 8'(want.frame_length));
      compare_field("read_byte", got.read_byte, want.read_byte);
      compare_field("slots_used", 8'(got.slots_used), 8'(want.slots_used));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [MODE_W-1:0]    in_mode;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic [SEL_W-1:0]     in_slot_sel;
  logic [POS_IN_W-1:0]  in_byte_pos;
  logic                 out_valid;
  logic                 out_ready;
  logic [EV_W-1:0]      out_event_res;
  logic [SEL_W-1:0]     out_slot_index;
  logic [LEN_OUT_W-1:0] out_frame_length;
  logic [BYTE_W-1:0]    out_read_byte;
  logic [CNT_W-1:0]     out_slots_used;

  frame_scoreboard   sb = new();
  logic [BYTE_W-1:0] cur_header  = HEADER_RESET;
  logic [BYTE_W-1:0] cur_timeout = TIMEOUT_RESET;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                hold_req       = 0;
  int                items_sent     = 0;
  int                quiet_cycles   = 0;

  header_length_checksum_frame_receiver_core #(
    .NUM_SLOTS (NUM_SLOTS),
    .SLOT_BYTES(SLOT_BYTES)
  ) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_rx_byte      (in_rx_byte),
    .in_slot_sel     (in_slot_sel),
    .in_byte_pos     (in_byte_pos),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_res   (out_event_res),
    .out_slot_index  (out_slot_index),
    .out_frame_length(out_frame_length),
    .out_read_byte   (out_read_byte),
    .out_slots_used  (out_slots_used)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // beat monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_request({in_mode, in_rx_byte, in_slot_sel, in_byte_pos});
      if (out_valid && out_ready)
        sb.check_result({out_event_res, out_slot_index, out_frame_length,
                         out_read_byte, out_slots_used});
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[header_length_checksum_frame_receiver_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // request beat with random don't-care fields
  function automatic hlcfr_item_t any_item(logic [MODE_W-1:0] m);
    hlcfr_item_t it;
    it.mode     = m;
    it.rx_byte  = BYTE_W'($urandom_range(255));
    it.slot_sel = SEL_W'($urandom_range(15));
    it.byte_pos = POS_IN_W'($urandom_range(15));
    return it;
  endfunction

  function automatic hlcfr_item_t byte_item(logic [BYTE_W-1:0] b);
    hlcfr_item_t it;
    it         = any_item(MODE_BYTE);
    it.rx_byte = b;
    return it;
  endfunction

  function automatic hlcfr_item_t make_release();
    hlcfr_item_t it;
    it = any_item(MODE_RELEASE);
    if ($urandom_range(4) != 0) it.slot_sel = SEL_W'($urandom_range(NUM_SLOTS - 1));
    return it;
  endfunction

  // reads only hit store bytes already written, or fall outside the slots
  function automatic hlcfr_item_t make_read();
    hlcfr_item_t it;
    int          start;
    int          idx;
    it = any_item(MODE_READ);
    it.slot_sel = SEL_W'($urandom_range(15, NUM_SLOTS));
    if ($urandom_range(4) == 0) return it;
    start = $urandom_range(STORE_BYTES - 1);
    for (int k = 0; k < STORE_BYTES; k++) begin
      idx = (start + k) % STORE_BYTES;
      if (sb.written[idx]) begin
        it.slot_sel = SEL_W'(idx / SLOT_BYTES);
        it.byte_pos = POS_IN_W'(idx % SLOT_BYTES);
        return it;
      end
    end
    return it;
  endfunction

  function automatic hlcfr_item_t side_item();
    int pick;
    pick = $urandom_range(2);
    if (pick == 0 && cur_timeout != 0) return any_item(MODE_TICK);
    if (pick == 1) return make_release();
    return make_read();
  endfunction

  // offer one beat, with random idle cycles first, and hold it until taken
  task automatic send_item(hlcfr_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= it.mode;
    in_rx_byte  <= it.rx_byte;
    in_slot_sel <= it.slot_sel;
    in_byte_pos <= it.byte_pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(any_item(MODE_TICK));
  endtask

  // frame of header, length, payload and checksum; cut short after cut bytes
  task automatic send_frame(int len, bit good, int cut);
    logic [BYTE_W-1:0] fb[$];
    logic [SUM_W-1:0]  sum;
    logic [BYTE_W-1:0] b;
    int                i;
    fb.push_back(cur_header);
    fb.push_back(BYTE_W'(len));
    if (len >= MIN_FRAME_LEN && len <= SLOT_BYTES) begin
      for (i = 2; i < len - 1; i++) begin
        b = BYTE_W'($urandom_range(255));
        // payload equal to the header restarts the frame; keep that rare
        if (b == cur_header && $urandom_range(9) != 0) b = b ^ 8'h01;
        fb.push_back(b);
      end
      sum = '0;
      foreach (fb[j]) sum = sum + fb[j][SUM_W-1:0];
      fb.push_back(good ? {4'h0, sum} : ({4'h0, sum} ^ BYTE_W'($urandom_range(255, 1))));
    end
    for (i = 0; i < cut && i < fb.size(); i++) begin
      if (i > 0 && $urandom_range(9) == 0) send_item(side_item());
      send_item(byte_item(fb[i]));
    end
  endtask

  // mostly well-formed frames, some bad checksum, bad length or truncated
  task automatic send_random_frame();
    int kind;
    int len;
    int cut;
    kind = $urandom_range(99);
    len  = $urandom_range(SLOT_BYTES, MIN_FRAME_LEN);
    if (kind >= 86 && kind < 93)
      len = ($urandom_range(1) == 1) ? $urandom_range(MIN_FRAME_LEN - 1, 0)
                                     : $urandom_range(255, SLOT_BYTES + 1);
    cut = (kind >= 93) ? $urandom_range(len - 1, 1) : len;
    send_frame(len, kind < 78, cut);
    // a truncated frame is sometimes left to time out
    if (kind >= 93 && $urandom_range(1) == 1 && cur_timeout < 40)
      send_ticks(int'(cur_timeout) + 1);
  endtask

  task automatic random_step();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) send_random_frame();
    else if (pick < 68) send_item(make_release());
    else if (pick < 83) send_item(make_read());
    else if (pick < 91)
      send_ticks(($urandom_range(1) == 1 && cur_timeout < 40) ? int'(cur_timeout) + 1
                                                             : $urandom_range(3, 1));
    else send_item(byte_item(BYTE_W'($urandom_range(255))));
  endtask

  // stop offering and wait until every owed result beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // both registers, written back to back while the block is idle
  task automatic configure(logic [BYTE_W-1:0] hdr, logic [BYTE_W-1:0] tmo);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEADER;
    cfg_data  <= hdr;
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    cfg_we           <= 1'b0;
    cur_header       = hdr;
    cur_timeout      = tmo;
    sb.header_value  = hdr;
    sb.timeout_ticks = tmo;
  endtask

  task automatic run_phase(int n, int idle_pct, int stall_pct,
                           logic [BYTE_W-1:0] hdr, logic [BYTE_W-1:0] tmo);
    int target;
    drain();
    configure(hdr, tmo);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_sent + n;
    while (items_sent < target) random_step();
  endtask

  initial begin
    logic [BYTE_W-1:0] opening_bytes[16];
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_HEADER;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    in_mode     <= MODE_BYTE;
    in_rx_byte  <= '0;
    in_slot_sel <= '0;
    in_byte_pos <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle requests, good frame, checksum error, bad lengths, restart
    send_item(byte_item(8'h00));
    send_item(any_item(MODE_TICK));
    send_item('{MODE_RELEASE, 8'hFF, 4'h0, 4'hF});
    send_item('{MODE_RELEASE, 8'h00, 4'hF, 4'h0});
    send_item('{MODE_READ, 8'h00, 4'hF, 4'hF});
    opening_bytes = '{HEADER_RESET, 8'h04, 8'h3C, 8'h05,
                      HEADER_RESET, 8'h03, 8'hFF,
                      HEADER_RESET, 8'h02,
                      HEADER_RESET, 8'h11,
                      HEADER_RESET, 8'h05, HEADER_RESET, 8'h03, 8'h08};
    foreach (opening_bytes[i]) send_item(byte_item(opening_bytes[i]));
    send_item('{MODE_READ, 8'h00, 4'h0, 4'h3});
    send_item('{MODE_READ, 8'h00, 4'h2, 4'h1});
    send_item('{MODE_RELEASE, 8'h00, 4'h0, 4'h0});
    send_item('{MODE_RELEASE, 8'h00, 4'h0, 4'h0});

    // no idling, timeout register set to one
    run_phase(300, 0, 0, 8'h3C, 8'd1);

    // idle sender, header zero, timeout never fires even past saturation
    run_phase(350, 57, 0, 8'h00, 8'hFF);
    send_item(byte_item(cur_header));
    send_ticks(258);

    // stalling receiver, header all ones, timeout on the first tick
    run_phase(350, 0, 57, 8'hFF, 8'd0);
    // long receiver hold-off while reads keep coming: fills the block
    hold_req = HOLD_CYCLES;
    repeat (30) send_item(make_read());

    // both sides idle, reset register values
    run_phase(400, 30, 30, HEADER_RESET, TIMEOUT_RESET);

    // no idling, random settings
    run_phase(300, 0, 0, BYTE_W'($urandom_range(255, 17)), BYTE_W'($urandom_range(40, 2)));

    drain();
    if (sb.pending() != 0) sb.report("result beats never arrived");
    if (sb.errors == 0) begin
      $display("[header_length_checksum_frame_receiver_core] OK");
    end else begin
      $display("[header_length_checksum_frame_receiver_core] ERROR");
    end
    $finish;
  end

endmodule
